@@ rtl/core/scs1kd_pkg.sv @@
`timescale 1ns / 1ps

package scs1kd_pkg;

	// Key buffer geometry: a ring that keeps FIFO_DEPTH-1 entries
	localparam int FIFO_DEPTH = 64;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	// Translation tables cover key numbers 0 .. TABLE_LEN-1
	localparam int TABLE_LEN = 88;
	localparam int KEY_W     = 7;

	// Command codes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Scancode bytes and key numbers
	localparam logic [7:0]       SC_PREFIX     = 8'hE0;
	localparam logic [KEY_W-1:0] KEY_SHIFT_L   = 7'h2A;
	localparam logic [KEY_W-1:0] KEY_SHIFT_R   = 7'h36;
	localparam logic [KEY_W-1:0] KEY_CTRL      = 7'h1D;
	localparam logic [KEY_W-1:0] KEY_ALT       = 7'h38;
	localparam logic [KEY_W-1:0] KEY_CAPS      = 7'h3A;
	localparam logic [KEY_W-1:0] KEY_NUM       = 7'h45;
	localparam logic [KEY_W-1:0] KEY_SCROLL    = 7'h46;
	localparam logic [KEY_W-1:0] KEY_F1        = 7'h3B;
	localparam logic [KEY_W-1:0] KEY_F10       = 7'h44;
	localparam logic [KEY_W-1:0] KEY_F11       = 7'h57;
	localparam logic [KEY_W-1:0] KEY_F12       = 7'h58;
	localparam logic [KEY_W-1:0] KEY_UP        = 7'h48;
	localparam logic [KEY_W-1:0] KEY_ARROW_DN  = 7'h50;
	localparam logic [KEY_W-1:0] KEY_ARROW_LT  = 7'h4B;
	localparam logic [KEY_W-1:0] KEY_ARROW_RT  = 7'h4D;
	localparam logic [KEY_W-1:0] KEY_PGUP      = 7'h49;
	localparam logic [KEY_W-1:0] KEY_PGDN      = 7'h51;
	localparam logic [KEY_W-1:0] KEY_LINE_HOME = 7'h47;
	localparam logic [KEY_W-1:0] KEY_END       = 7'h4F;
	localparam logic [KEY_W-1:0] KEY_INS       = 7'h52;
	localparam logic [KEY_W-1:0] KEY_DEL       = 7'h53;

	// Special key numbers
	localparam logic [7:0] SP_UP    = 8'd0;
	localparam logic [7:0] SP_DOWN  = 8'd1;
	localparam logic [7:0] SP_LEFT  = 8'd2;
	localparam logic [7:0] SP_RIGHT = 8'd3;
	localparam logic [7:0] SP_PGUP  = 8'd4;
	localparam logic [7:0] SP_PGDN  = 8'd5;
	localparam logic [7:0] SP_HOME  = 8'd6;
	localparam logic [7:0] SP_END   = 8'd7;
	localparam logic [7:0] SP_INS   = 8'd8;
	localparam logic [7:0] SP_DEL   = 8'd9;
	localparam logic [7:0] SP_F1    = 8'd10;
	localparam logic [7:0] SP_F11   = 8'd20;
	localparam logic [7:0] SP_F12   = 8'd21;

	// Modifier bit positions
	localparam int MOD_SHIFT_L = 0;
	localparam int MOD_SHIFT_R = 1;
	localparam int MOD_CTRL_L  = 2;
	localparam int MOD_CTRL_R  = 3;
	localparam int MOD_ALT_L   = 4;
	localparam int MOD_ALT_R   = 5;
	localparam int MOD_CAPS    = 6;
	localparam int MOD_NUM     = 7;
	localparam int MOD_SCROLL  = 8;

	typedef struct packed {
		logic       opcode;
		logic [7:0] scan_byte;
	} cmd_t;

	typedef struct packed {
		logic       read_valid;
		logic       is_special;
		logic [7:0] key_code;
		logic [8:0] modifier_bits;
		logic       buffer_nonempty;
		logic       dropped;
	} res_t;

	typedef struct packed {
		logic       special;
		logic [7:0] code;
	} entry_t;

	// Decoder verdict for one scancode byte
	typedef struct packed {
		logic       push;
		entry_t     entry;
		logic [8:0] mods;
		logic       prefix;
	} dec_t;

	localparam logic [7:0] PLAIN_MAP [TABLE_LEN] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
		8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
		8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
		8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B,
		8'h31, 8'h32, 8'h33, 8'h30, 8'h2E,
		8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] SHIFT_MAP [TABLE_LEN] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
		8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
		8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
		8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B,
		8'h31, 8'h32, 8'h33, 8'h30, 8'h2E,
		8'h00, 8'h00, 8'h00, 8'h00
	};

	// Advance a ring pointer, wrapping at FIFO_DEPTH
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/scs1kd_decode.sv @@
`timescale 1ns / 1ps

module scs1kd_decode
	import scs1kd_pkg::*;
(
	input  logic [7:0] scan_byte,
	input  logic [8:0] mods,
	input  logic       prefix,
	output dec_t       dec
);

	logic             rel;
	logic [KEY_W-1:0] key;
	logic [KEY_W-1:0] tab_idx;
	logic             shift_on;
	logic             ctrl_on;
	logic [7:0]       ch_raw;
	logic [7:0]       ch_case;
	logic [7:0]       ch;
	logic             nav_hit;
	logic [7:0]       nav_code;

	assign rel = scan_byte[7];
	assign key = scan_byte[6:0];

	// Look up the character for the current shift, caps lock and ctrl state
	always_comb begin
		shift_on = mods[MOD_SHIFT_L] | mods[MOD_SHIFT_R];
		ctrl_on  = mods[MOD_CTRL_L] | mods[MOD_CTRL_R];
		tab_idx  = (key < KEY_W'(TABLE_LEN)) ? key : '0;
		ch_raw   = shift_on ? SHIFT_MAP[tab_idx] : PLAIN_MAP[tab_idx];
		ch_case  = ch_raw;
		if (!shift_on && mods[MOD_CAPS] && ch_raw >= 8'h61 && ch_raw <= 8'h7A) begin
			ch_case = ch_raw - 8'd32;
		end
		ch = ch_case;
		if (ctrl_on && ((ch_case >= 8'h61 && ch_case <= 8'h7A) ||
				(ch_case >= 8'h41 && ch_case <= 8'h5A))) begin
			ch = {3'b000, ch_case[4:0]};
		end
	end

	// Map prefixed navigation keys
	always_comb begin
		nav_hit  = 1'b1;
		nav_code = SP_UP;
		case (key)
			KEY_UP:        nav_code = SP_UP;
			KEY_ARROW_DN:  nav_code = SP_DOWN;
			KEY_ARROW_LT:  nav_code = SP_LEFT;
			KEY_ARROW_RT:  nav_code = SP_RIGHT;
			KEY_PGUP:      nav_code = SP_PGUP;
			KEY_PGDN:      nav_code = SP_PGDN;
			KEY_LINE_HOME: nav_code = SP_HOME;
			KEY_END:       nav_code = SP_END;
			KEY_INS:       nav_code = SP_INS;
			KEY_DEL:       nav_code = SP_DEL;
			default:       nav_hit  = 1'b0;
		endcase
	end

	// Track prefix and modifiers, pick the entry to buffer
	always_comb begin
		dec.push          = 1'b0;
		dec.entry.special = 1'b0;
		dec.entry.code    = '0;
		dec.mods          = mods;
		dec.prefix        = prefix;
		if (scan_byte == SC_PREFIX) begin
			dec.prefix = 1'b1;
		end else if (prefix) begin
			dec.prefix = 1'b0;
			if (key == KEY_CTRL) begin
				dec.mods[MOD_CTRL_R] = !rel;
			end else if (key == KEY_ALT) begin
				dec.mods[MOD_ALT_R] = !rel;
			end else if (nav_hit && !rel) begin
				dec.push          = 1'b1;
				dec.entry.special = 1'b1;
				dec.entry.code    = nav_code;
			end
		end else begin
			case (key)
				KEY_SHIFT_L: dec.mods[MOD_SHIFT_L] = !rel;
				KEY_SHIFT_R: dec.mods[MOD_SHIFT_R] = !rel;
				KEY_CTRL:    dec.mods[MOD_CTRL_L]  = !rel;
				KEY_ALT:     dec.mods[MOD_ALT_L]   = !rel;
				KEY_CAPS:    dec.mods[MOD_CAPS]    = mods[MOD_CAPS] ^ !rel;
				KEY_NUM:     dec.mods[MOD_NUM]     = mods[MOD_NUM] ^ !rel;
				KEY_SCROLL:  dec.mods[MOD_SCROLL]  = mods[MOD_SCROLL] ^ !rel;
				default: begin
					if (!rel) begin
						if (key >= KEY_F1 && key <= KEY_F10) begin
							dec.push          = 1'b1;
							dec.entry.special = 1'b1;
							dec.entry.code    = SP_F1 + {1'b0, key - KEY_F1};
						end else if (key == KEY_F11) begin
							dec.push          = 1'b1;
							dec.entry.special = 1'b1;
							dec.entry.code    = SP_F11;
						end else if (key == KEY_F12) begin
							dec.push          = 1'b1;
							dec.entry.special = 1'b1;
							dec.entry.code    = SP_F12;
						end else if (key < KEY_W'(TABLE_LEN) && ch != 8'h00) begin
							dec.push       = 1'b1;
							dec.entry.code = ch;
						end
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/core/scancode_set1_key_decoder_unit.sv @@
`timescale 1ns / 1ps

// Scancode set 1 key decoder with a buffered key queue.
//
// Command channel (cmd_valid / cmd_stall / cmd): each beat either carries
// one raw scancode byte (opcode scan) or asks to pop one buffered key
// (opcode pop). Result channel (res_valid / res_stall / res): every command
// beat yields exactly one result beat, in order.
//
// The result beat is registered: a command beat passes through the command
// register and then the result register, and a stall on the result side can
// hold it between them. Throughput is one beat per cycle while res_stall is
// low; decode, table lookup and the queue access all sit in the single stage
// between those two registers, and the queue memory has one write and one
// registered read port.
//
// The queue keeps FIFO_DEPTH-1 keys; a key produced while it is full is lost
// and flagged in the dropped field. Reset clears modifiers, the prefix flag
// and the queue pointers; the queue memory itself is not cleared.
// While res_stall is high a waiting result holds; one more command beat is
// taken into the command register, then cmd_stall rises.
module scancode_set1_key_decoder_unit
	import scs1kd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic             cmd_valid_s1;
	cmd_t             cmd_s1;
	logic             res_valid_q;
	logic             pop_ok_q;
	logic [8:0]       mods_out_q;
	logic             nonempty_q;
	logic             dropped_q;
	entry_t           rdata_q;
	logic [8:0]       mods_q;
	logic             prefix_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	entry_t           mem_q [FIFO_DEPTH];

	dec_t             dec;
	logic             out_load;
	logic             is_pop;
	logic             nonempty;
	logic             full;
	logic             pop_ok;
	logic             push_req;
	logic             push_ok;
	logic [PTR_W-1:0] rd_ptr_n;
	logic [PTR_W-1:0] wr_ptr_n;
	logic [8:0]       mods_n;

	scs1kd_decode u_decode (
		.scan_byte (cmd_s1.scan_byte),
		.mods      (mods_q),
		.prefix    (prefix_q),
		.dec       (dec)
	);

	// Move the command stage forward when the result register frees up
	assign out_load  = cmd_valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = cmd_valid_s1 && !out_load;

	// Resolve queue access for the item in the command stage
	always_comb begin
		is_pop   = (cmd_s1.opcode == OP_POP);
		nonempty = (rd_ptr_q != wr_ptr_q);
		full     = (ptr_inc(wr_ptr_q) == rd_ptr_q);
		pop_ok   = is_pop && nonempty;
		push_req = !is_pop && dec.push;
		push_ok  = push_req && !full;
		rd_ptr_n = pop_ok ? ptr_inc(rd_ptr_q) : rd_ptr_q;
		wr_ptr_n = push_ok ? ptr_inc(wr_ptr_q) : wr_ptr_q;
		mods_n   = is_pop ? mods_q : dec.mods;
	end

	// Capture the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			cmd_valid_s1 <= 1'b1;
		end else if (out_load) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Update keyboard state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q   <= '0;
			prefix_q <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else if (out_load) begin
			mods_q   <= mods_n;
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			if (!is_pop) begin
				prefix_q <= dec.prefix;
			end
		end
	end

	// Queue memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (out_load && push_ok) begin
			mem_q[wr_ptr_q] <= dec.entry;
		end
		if (out_load && pop_ok) begin
			rdata_q <= mem_q[rd_ptr_q];
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pop_ok_q   <= pop_ok;
			mods_out_q <= mods_n;
			nonempty_q <= (rd_ptr_n != wr_ptr_n);
			dropped_q  <= push_req && full;
		end
	end

	assign res_valid           = res_valid_q;
	assign res.read_valid      = pop_ok_q;
	assign res.is_special      = pop_ok_q & rdata_q.special;
	assign res.key_code        = pop_ok_q ? rdata_q.code : 8'h00;
	assign res.modifier_bits   = mods_out_q;
	assign res.buffer_nonempty = nonempty_q;
	assign res.dropped         = dropped_q;

	// A stall only comes from an occupied command stage
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> cmd_valid_s1)
		else $error("command stall without a held item");

	// A stored key advances the write pointer
	a_push_moves_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && push_ok |=> wr_ptr_q != $past(wr_ptr_q))
		else $error("write pointer did not advance on push");

	// A full queue is never written past
	a_full_holds_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && push_req && full |=> wr_ptr_q == $past(wr_ptr_q))
		else $error("write pointer moved while queue full");

	// A pop result never reports a lost key
	a_pop_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && pop_ok_q |-> !dropped_q)
		else $error("pop result flagged as dropped");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import scs1kd_pkg::*;

	localparam int ITEM_TARGET = 1050;
	localparam int CALM_TAIL   = 150;
	localparam int SQUEEZE_LEN = 300;

	// Unshifted characters by key number
	localparam logic [7:0] BARE_CHARS [TABLE_LEN] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Characters while a shift key is held
	localparam logic [7:0] SHIFT_CHARS [TABLE_LEN] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Navigation keys behind the E0 prefix and their special numbers
	localparam logic [KEY_W-1:0] NAV_KEYS [10] = '{
		KEY_UP, KEY_ARROW_DN, KEY_ARROW_LT, KEY_ARROW_RT, KEY_PGUP,
		KEY_PGDN, KEY_LINE_HOME, KEY_END, KEY_INS, KEY_DEL
	};
	localparam logic [7:0] NAV_CODES [10] = '{
		SP_UP, SP_DOWN, SP_LEFT, SP_RIGHT, SP_PGUP,
		SP_PGDN, SP_HOME, SP_END, SP_INS, SP_DEL
	};

	localparam res_t NO_KEY  = '0;
	localparam res_t CAPS_ON = '{1'b0, 1'b0, 8'h00, 9'h040, 1'b0, 1'b0};

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t want;
	} row_t;

	// Opening sequence: extremes, locks, shift, caps, ctrl, E0 handling
	row_t opening_rows [28] = '{
		'{{OP_POP, 8'h00}, 1'b1, NO_KEY},
		'{{OP_SCAN, 8'h00}, 1'b1, NO_KEY},
		'{{OP_SCAN, 8'hFF}, 1'b1, NO_KEY},
		'{{OP_SCAN, 8'h7F}, 1'b1, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_CAPS}, 1'b1, CAPS_ON},
		'{{OP_SCAN, 1'b1, KEY_CAPS}, 1'b1, CAPS_ON},
		'{{OP_SCAN, 8'h1E}, 1'b0, NO_KEY},
		'{{OP_SCAN, 8'h9E}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_SHIFT_L}, 1'b0, NO_KEY},
		'{{OP_SCAN, 8'h03}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b1, KEY_SHIFT_L}, 1'b0, NO_KEY},
		'{{OP_SCAN, SC_PREFIX}, 1'b0, NO_KEY},
		'{{OP_SCAN, SC_PREFIX}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_CTRL}, 1'b0, NO_KEY},
		'{{OP_SCAN, 8'h2E}, 1'b0, NO_KEY},
		'{{OP_SCAN, SC_PREFIX}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b1, KEY_CTRL}, 1'b0, NO_KEY},
		'{{OP_SCAN, SC_PREFIX}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_UP}, 1'b0, NO_KEY},
		'{{OP_SCAN, SC_PREFIX}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b1, KEY_UP}, 1'b0, NO_KEY},
		'{{OP_SCAN, SC_PREFIX}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_SHIFT_L}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_F12}, 1'b0, NO_KEY},
		'{{OP_SCAN, 1'b0, KEY_NUM}, 1'b0, NO_KEY},
		'{{OP_POP, 8'hFF}, 1'b0, NO_KEY},
		'{{OP_POP, 8'h55}, 1'b0, NO_KEY},
		'{{OP_POP, 8'hAA}, 1'b0, NO_KEY}
	};

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	// Decoder state as seen by the testbench
	logic [8:0] mods_now = '0;
	logic       e0_seen  = 1'b0;
	entry_t     key_store [$];
	res_t       due_replies [$];

	int mismatches = 0;
	int counted    = 0;
	int offered    = 0;
	int gap_pct    = 10;
	bit gaps_off   = 1'b0;
	bit calm       = 1'b0;
	bit squeeze_req = 1'b0;

	scancode_set1_key_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	// Apply one command beat to the tracked state and return the reply it earns
	function automatic res_t decode_cmd(cmd_t c);
		res_t             r;
		entry_t           e;
		logic             rel;
		logic [KEY_W-1:0] key;
		logic [7:0]       ch;
		logic             push;
		r    = '0;
		e    = '0;
		push = 1'b0;
		ch   = '0;
		rel  = c.scan_byte[7];
		key  = c.scan_byte[6:0];
		if (c.opcode == OP_POP) begin
			if (key_store.size() != 0) begin
				e = key_store.pop_front();
				r.read_valid = 1'b1;
				r.is_special = e.special;
				r.key_code   = e.code;
			end
		end else if (c.scan_byte == SC_PREFIX) begin
			e0_seen = 1'b1;
		end else if (e0_seen) begin
			// Prefixed: right ctrl/alt, navigation on make, drop the rest
			e0_seen   = 1'b0;
			e.special = 1'b1;
			case (key)
				KEY_CTRL: mods_now[MOD_CTRL_R] = !rel;
				KEY_ALT:  mods_now[MOD_ALT_R]  = !rel;
				default: begin
					for (int i = 0; i < 10; i++) begin
						if (key == NAV_KEYS[i]) begin
							e.code = NAV_CODES[i];
							push   = !rel;
						end
					end
				end
			endcase
		end else begin
			case (key)
				KEY_SHIFT_L: mods_now[MOD_SHIFT_L] = !rel;
				KEY_SHIFT_R: mods_now[MOD_SHIFT_R] = !rel;
				KEY_CTRL:    mods_now[MOD_CTRL_L]  = !rel;
				KEY_ALT:     mods_now[MOD_ALT_L]   = !rel;
				KEY_CAPS:    mods_now[MOD_CAPS]    = mods_now[MOD_CAPS] ^ !rel;
				KEY_NUM:     mods_now[MOD_NUM]     = mods_now[MOD_NUM] ^ !rel;
				KEY_SCROLL:  mods_now[MOD_SCROLL]  = mods_now[MOD_SCROLL] ^ !rel;
				default: if (!rel) begin
					if (key >= KEY_F1 && key <= KEY_F10) begin
						e.special = 1'b1;
						e.code    = SP_F1 + 8'(key - KEY_F1);
						push      = 1'b1;
					end else if (key == KEY_F11) begin
						e.special = 1'b1;
						e.code    = SP_F11;
						push      = 1'b1;
					end else if (key == KEY_F12) begin
						e.special = 1'b1;
						e.code    = SP_F12;
						push      = 1'b1;
					end else if (key < TABLE_LEN) begin
						// Shift picks the shifted table; caps only lifts letters
						if (mods_now[MOD_SHIFT_L] || mods_now[MOD_SHIFT_R]) begin
							ch = SHIFT_CHARS[key];
						end else begin
							ch = BARE_CHARS[key];
							if (mods_now[MOD_CAPS] && ch >= "a" && ch <= "z") begin
								ch = ch - 8'd32;
							end
						end
						// Ctrl folds letters onto 1..26
						if (mods_now[MOD_CTRL_L] || mods_now[MOD_CTRL_R]) begin
							if (ch >= "a" && ch <= "z") begin
								ch = ch - "a" + 8'd1;
							end else if (ch >= "A" && ch <= "Z") begin
								ch = ch - "A" + 8'd1;
							end
						end
						e.code = ch;
						push   = (ch != 8'd0);
					end
				end
			endcase
		end
		// Queue the key, or flag it lost when the ring is full
		if (push) begin
			if (key_store.size() == FIFO_DEPTH - 1) begin
				r.dropped = 1'b1;
			end else begin
				key_store.push_back(e);
			end
		end
		r.modifier_bits   = mods_now;
		r.buffer_nonempty = (key_store.size() != 0);
		return r;
	endfunction

	task automatic log_mismatch(string what);
		mismatches++;
		if (mismatches <= 50) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	// Compare one accepted reply beat with the oldest one due
	task automatic take_reply(res_t got);
		res_t want;
		if (due_replies.size() == 0) begin
			log_mismatch($sformatf("reply beat %h with none due", got));
			return;
		end
		want = due_replies.pop_front();
		if (got.read_valid !== want.read_valid) begin
			log_mismatch($sformatf("read_valid %b, due %b", got.read_valid, want.read_valid));
		end
		if (got.is_special !== want.is_special) begin
			log_mismatch($sformatf("is_special %b, due %b", got.is_special, want.is_special));
		end
		if (got.key_code !== want.key_code) begin
			log_mismatch($sformatf("key_code %h, due %h", got.key_code, want.key_code));
		end
		if (got.modifier_bits !== want.modifier_bits) begin
			log_mismatch($sformatf("modifier_bits %h, due %h",
				got.modifier_bits, want.modifier_bits));
		end
		if (got.buffer_nonempty !== want.buffer_nonempty) begin
			log_mismatch($sformatf("buffer_nonempty %b, due %b",
				got.buffer_nonempty, want.buffer_nonempty));
		end
		if (got.dropped !== want.dropped) begin
			log_mismatch($sformatf("dropped %b, due %b", got.dropped, want.dropped));
		end
	endtask

	// Offer one command beat, with an optional idle burst first; hold until taken
	task automatic offer(cmd_t c);
		int gap;
		if (!gaps_off && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 12);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		offered++;
		if (offered % 64 == 0) begin
			gap_pct = pick_rate();
		end
	endtask

	// Send a beat, book its reply and count it
	task automatic issue(cmd_t c);
		res_t r;
		offer(c);
		r = decode_cmd(c);
		due_replies.push_back(r);
		counted++;
	endtask

	task automatic scan(logic [7:0] b);
		issue({OP_SCAN, b});
	endtask

	task automatic pop_key();
		issue({OP_POP, 8'($urandom)});
	endtask

	initial begin : stimulus
		res_t             reply;
		int               pick;
		int               held;
		int               idx;
		logic [KEY_W-1:0] key;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the opening rows
		foreach (opening_rows[i]) begin
			offer(opening_rows[i].c);
			reply = decode_cmd(opening_rows[i].c);
			due_replies.push_back(opening_rows[i].typed ? opening_rows[i].want : reply);
		end

		// Fill the ring past full with letters, then drain it past empty
		repeat (80) scan({1'b0, 7'($urandom_range(16, 25))});
		repeat (70) pop_key();

		while (counted < ITEM_TARGET) begin
			// Hold the result side off for a long stretch while beats keep coming
			if (!squeeze_req && counted >= 400) begin
				squeeze_req = 1'b1;
				gaps_off    = 1'b1;
				repeat (20) begin
					scan({1'b0, 7'($urandom_range(0, 88))});
					pop_key();
				end
				gaps_off = calm;
			end
			if (!calm && counted >= ITEM_TARGET - CALM_TAIL) begin
				calm     = 1'b1;
				gaps_off = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// Keystroke, possibly under a held modifier
				key  = 7'($urandom_range(0, 88));
				held = $urandom_range(0, 6);
				case (held)
					1: scan({1'b0, KEY_SHIFT_L});
					2: scan({1'b0, KEY_SHIFT_R});
					3: scan({1'b0, KEY_CTRL});
					4: begin
						scan(SC_PREFIX);
						scan({1'b0, KEY_CTRL});
					end
					5: begin
						scan(SC_PREFIX);
						scan({1'b0, KEY_ALT});
					end
					6: scan({1'b0, KEY_ALT});
					default: ;
				endcase
				scan({1'b0, key});
				if ($urandom_range(0, 3) != 0) begin
					scan({1'b1, key});
				end
				// Leave the modifier held now and then so combinations build up
				if ($urandom_range(0, 4) != 0) begin
					case (held)
						1: scan({1'b1, KEY_SHIFT_L});
						2: scan({1'b1, KEY_SHIFT_R});
						3: scan({1'b1, KEY_CTRL});
						4: begin
							scan(SC_PREFIX);
							scan({1'b1, KEY_CTRL});
						end
						5: begin
							scan(SC_PREFIX);
							scan({1'b1, KEY_ALT});
						end
						6: scan({1'b1, KEY_ALT});
						default: ;
					endcase
				end
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 3)) pop_key();
			end else if (pick < 78) begin
				// Navigation key make, followed by its break about half the time
				idx = $urandom_range(0, 9);
				scan(SC_PREFIX);
				scan({1'b0, NAV_KEYS[idx]});
				if ($urandom_range(0, 1) != 0) begin
					scan(SC_PREFIX);
					scan({1'b1, NAV_KEYS[idx]});
				end
			end else if (pick < 83) begin
				// Lock toggle
				case ($urandom_range(0, 2))
					0: key = KEY_CAPS;
					1: key = KEY_NUM;
					default: key = KEY_SCROLL;
				endcase
				scan({1'b0, key});
				scan({1'b1, key});
			end else if (pick < 93) begin
				scan(8'($urandom));
			end else begin
				// Prefix followed by anything
				scan(SC_PREFIX);
				scan(8'($urandom));
			end
		end

		// Drain and settle
		cmd_valid <= 1'b0;
		while (due_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_replies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Result side: check accepted beats and drive stall in random bursts
	initial begin : result_side
		int hold_left;
		int stall_pct;
		int tick;
		bit squeeze_done;
		hold_left    = 0;
		stall_pct    = 0;
		tick         = 0;
		squeeze_done = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				take_reply(res);
			end
			tick++;
			if (tick % 128 == 0) begin
				stall_pct = pick_rate();
			end
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left    = SQUEEZE_LEN;
			end else if (hold_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
				hold_left = $urandom_range(1, 12);
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Give up after a generous bound
	initial begin : watchdog
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
